>>> rtl/core/euler_angle_vector_rotation_core_defines.svh
// Assertion macros for the rotation core
`ifndef EULER_ANGLE_VECTOR_ROTATION_CORE_DEFINES_SVH
`define EULER_ANGLE_VECTOR_ROTATION_CORE_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle
`define EAVR_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define EAVR_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/eavr_pkg.sv
// ----------------------------------------------------------------------------
// eavr_pkg
// Shared constants, types and the CORDIC arctangent table of the rotation core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eavr_pkg;

   localparam int AngleBits     = 16;
   localparam int CompBits      = 16;
   localparam int TrigIter      = 16;
   localparam int CordicTabLen  = 24;
   localparam int CordicSteps   = (TrigIter > CordicTabLen) ? CordicTabLen : TrigIter;
   localparam int CordicW       = 34;
   localparam int ZW            = 33;
   localparam int TrigW         = 17;
   localparam int ProdW         = 34;
   localparam int AccW          = 36 + CompBits;
   localparam int ReqW          = 8 * ((3 * AngleBits + 3 * CompBits + 7) / 8);
   localparam int RspW          = 8 * ((3 * CompBits + 7) / 8);
   localparam logic signed [CordicW-1:0] CordicGain = CordicW'(652032874);

   typedef logic signed [AngleBits-1:0] angle_type;
   typedef logic signed [CompBits-1:0]  comp_type;
   typedef logic signed [TrigW-1:0]     trig_type;

   // Per-angle CORDIC working set
   typedef struct packed {
      logic signed [CordicW-1:0] x;
      logic signed [CordicW-1:0] y;
      logic signed [ZW-1:0]      z;
      logic                      neg;
   } cordic_type;

   function automatic logic signed [ZW-1:0] atan_at(input int idx);
      logic signed [ZW-1:0] v;
      v = '0;
      unique case (idx)
         0:  v = ZW'(536870912);
         1:  v = ZW'(316933406);
         2:  v = ZW'(167458907);
         3:  v = ZW'(85004756);
         4:  v = ZW'(42667331);
         5:  v = ZW'(21354465);
         6:  v = ZW'(10679838);
         7:  v = ZW'(5340245);
         8:  v = ZW'(2670163);
         9:  v = ZW'(1335087);
         10: v = ZW'(667544);
         11: v = ZW'(333772);
         12: v = ZW'(166886);
         13: v = ZW'(83443);
         14: v = ZW'(41722);
         15: v = ZW'(20861);
         16: v = ZW'(10430);
         17: v = ZW'(5215);
         18: v = ZW'(2608);
         19: v = ZW'(1304);
         20: v = ZW'(652);
         21: v = ZW'(326);
         22: v = ZW'(163);
         23: v = ZW'(81);
         default: v = '0;
      endcase
      return v;
   endfunction

   // Fold an angle into the right half plane; widen to a 32-bit turn value
   function automatic cordic_type cordic_seed(input angle_type ang);
      cordic_type s;
      logic [31:0] a;
      a = {ang, {(32 - AngleBits){1'b0}}};
      s.neg = a[31] ^ a[30];
      if (s.neg) begin
         a = a + 32'h8000_0000;
      end
      s.x = CordicGain;
      s.y = '0;
      s.z = ZW'(signed'(a));
      return s;
   endfunction

   function automatic cordic_type cordic_step(input cordic_type c, input int i);
      cordic_type r;
      logic signed [CordicW-1:0] xs, ys;
      xs = c.x >>> i;
      ys = c.y >>> i;
      r = c;
      if (!c.z[ZW-1]) begin
         r.x = c.x - ys;
         r.y = c.y + xs;
         r.z = c.z - atan_at(i);
      end else begin
         r.x = c.x + ys;
         r.y = c.y - xs;
         r.z = c.z + atan_at(i);
      end
      return r;
   endfunction

   // Round Q1.30 to Q1.15, clamp to +/-1, apply fold sign
   function automatic trig_type cordic_out(input logic signed [CordicW-1:0] v,
                                           input logic neg);
      logic signed [CordicW-1:0] r;
      trig_type t;
      r = (v + CordicW'(16384)) >>> 15;
      if (r > CordicW'(32768)) begin
         t = TrigW'(32768);
      end else if (r < -CordicW'(32768)) begin
         t = -TrigW'(32768);
      end else begin
         t = TrigW'(r);
      end
      return neg ? -t : t;
   endfunction

   function automatic logic signed [ProdW-1:0] rnd15(input logic signed [ProdW-1:0] v);
      return (v + ProdW'(16384)) >>> 15;
   endfunction

endpackage

>>> rtl/core/euler_angle_vector_rotation_core.sv
// ----------------------------------------------------------------------------
// euler_angle_vector_rotation_core
// Rotates a 3-vector by Rz(alpha) * Ry(beta) * Rx(gamma), pipelined CORDIC.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low to high)                         | tuser
//  req     | in  | angle_x angle_y angle_z in_x in_y in_z       | -
//  rsp     | out | out_x out_y out_z                           | saturated
//
//  The pipeline does two CORDIC steps per stage, then trig rounding, two
//  matrix product stages, two vector multiply-accumulate stages and the
//  saturating output register. One transfer per cycle is sustained while
//  rsp_tready stays high. On a stall, full stages hold while empty stages
//  still advance, so bubbles are squeezed out; reset clears only valid bits.
`timescale 1ns / 1ps
`include "euler_angle_vector_rotation_core_defines.svh"

module euler_angle_vector_rotation_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // angle_x, angle_y, angle_z, in_x, in_y, in_z
   input  logic [eavr_pkg::ReqW-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // out_x, out_y, out_z
   output logic [eavr_pkg::RspW-1:0] rsp_tdata,
   // saturated
   output logic                      rsp_tuser
);
   import eavr_pkg::*;

   localparam int CStages = (CordicSteps + 1) / 2;
   localparam int NStages = CStages + 6;

   // Valid per stage; stage k advances when it is empty or the stage downstream of it advances
   logic [NStages-1:0] vld_ff;
   logic [NStages-1:0] adv;

   always_comb begin
      adv[NStages-1] = !vld_ff[NStages-1] || rsp_tready;
      for (int k = NStages - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_tready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NStages; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // Input unpack
   angle_type ang_in [3];
   comp_type  vec_in [3];
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         ang_in[j] = req_tdata[j*AngleBits +: AngleBits];
         vec_in[j] = req_tdata[3*AngleBits + j*CompBits +: CompBits];
      end
   end

   // CORDIC stages: stage 0 takes the seed and does two steps
   cordic_type cor_ff [CStages][3];
   comp_type   cvec_ff [CStages][3];

   always_ff @(posedge clock) begin
      for (int k = 0; k < CStages; k++) begin
         if (adv[k]) begin
            for (int j = 0; j < 3; j++) begin
               cordic_type c;
               c = (k == 0) ? cordic_seed(ang_in[j]) : cor_ff[(k > 0) ? k - 1 : 0][j];
               if (2 * k < CordicSteps) c = cordic_step(c, 2 * k);
               if (2 * k + 1 < CordicSteps) c = cordic_step(c, 2 * k + 1);
               cor_ff[k][j]  <= c;
               cvec_ff[k][j] <= (k == 0) ? vec_in[j] : cvec_ff[(k > 0) ? k - 1 : 0][j];
            end
         end
      end
   end

   // Trig rounding stage: index 0 gamma, 1 beta, 2 alpha
   trig_type cos_ff [3];
   trig_type sin_ff [3];
   comp_type tvec_ff [3];
   localparam int ST = CStages;

   always_ff @(posedge clock) begin
      if (adv[ST]) begin
         for (int j = 0; j < 3; j++) begin
            cos_ff[j]  <= cordic_out(cor_ff[CStages-1][j].x, cor_ff[CStages-1][j].neg);
            sin_ff[j]  <= cordic_out(cor_ff[CStages-1][j].y, cor_ff[CStages-1][j].neg);
            tvec_ff[j] <= cvec_ff[CStages-1][j];
         end
      end
   end

   // First product stage
   logic signed [ProdW-1:0] casb_ff, sasb_ff, m00_ff, m10_ff, m21_ff, m22_ff, m20_ff;
   trig_type cg1_ff, sg1_ff, ca1_ff, sa1_ff;
   comp_type p1vec_ff [3];

   always_ff @(posedge clock) begin
      if (adv[ST+1]) begin
         casb_ff <= rnd15(ProdW'(cos_ff[2]) * ProdW'(sin_ff[1]));
         sasb_ff <= rnd15(ProdW'(sin_ff[2]) * ProdW'(sin_ff[1]));
         m00_ff  <= rnd15(ProdW'(cos_ff[2]) * ProdW'(cos_ff[1]));
         m10_ff  <= rnd15(ProdW'(sin_ff[2]) * ProdW'(cos_ff[1]));
         m21_ff  <= rnd15(ProdW'(cos_ff[1]) * ProdW'(sin_ff[0]));
         m22_ff  <= rnd15(ProdW'(cos_ff[1]) * ProdW'(cos_ff[0]));
         m20_ff  <= -ProdW'(sin_ff[1]);
         cg1_ff  <= cos_ff[0];
         sg1_ff  <= sin_ff[0];
         ca1_ff  <= cos_ff[2];
         sa1_ff  <= sin_ff[2];
         p1vec_ff <= tvec_ff;
      end
   end

   // Second product stage: compound coefficients
   logic signed [ProdW-1:0] m_ff [9];
   comp_type p2vec_ff [3];

   always_ff @(posedge clock) begin
      if (adv[ST+2]) begin
         m_ff[0] <= m00_ff;
         m_ff[1] <= rnd15(casb_ff * ProdW'(sg1_ff) - ProdW'(sa1_ff) * ProdW'(cg1_ff));
         m_ff[2] <= rnd15(casb_ff * ProdW'(cg1_ff) + ProdW'(sa1_ff) * ProdW'(sg1_ff));
         m_ff[3] <= m10_ff;
         m_ff[4] <= rnd15(sasb_ff * ProdW'(sg1_ff) + ProdW'(ca1_ff) * ProdW'(cg1_ff));
         m_ff[5] <= rnd15(sasb_ff * ProdW'(cg1_ff) - ProdW'(ca1_ff) * ProdW'(sg1_ff));
         m_ff[6] <= m20_ff;
         m_ff[7] <= m21_ff;
         m_ff[8] <= m22_ff;
         p2vec_ff <= p1vec_ff;
      end
   end

   // Vector products, then row sums
   logic signed [AccW-1:0] pr_ff [9];
   logic signed [AccW-1:0] acc_ff [3];

   always_ff @(posedge clock) begin
      if (adv[ST+3]) begin
         // coefficients stay within sqrt(2) in Q1.15, so the product fits ProdW
         for (int i = 0; i < 9; i++) begin
            pr_ff[i] <= AccW'(m_ff[i] * ProdW'(p2vec_ff[i%3]));
         end
      end
      if (adv[ST+4]) begin
         for (int r = 0; r < 3; r++) begin
            acc_ff[r] <= pr_ff[3*r] + pr_ff[3*r+1] + pr_ff[3*r+2];
         end
      end
   end

   // Round and saturate
   localparam logic signed [AccW-1:0] MaxV = AccW'((64'sd1 <<< (CompBits - 1)) - 1);
   localparam logic signed [AccW-1:0] MinV = -MaxV - AccW'(1);
   comp_type out_ff [3];
   logic     sat_ff;

   always_ff @(posedge clock) begin
      if (adv[ST+5]) begin
         logic clip;
         logic signed [AccW-1:0] v;
         clip = 1'b0;
         for (int r = 0; r < 3; r++) begin
            v = (acc_ff[r] + AccW'(16384)) >>> 15;
            if (v > MaxV) begin
               v = MaxV;
               clip = 1'b1;
            end else if (v < MinV) begin
               v = MinV;
               clip = 1'b1;
            end
            out_ff[r] <= CompBits'(v);
         end
         sat_ff <= clip;
      end
   end

   assign rsp_tvalid = vld_ff[NStages-1];
   always_comb begin
      rsp_tdata = '0;
      for (int r = 0; r < 3; r++) begin
         rsp_tdata[r*CompBits +: CompBits] = out_ff[r];
      end
   end
   assign rsp_tuser = sat_ff;

   `EAVR_ASSERT_IMPL(a_ready_when_empty, clock, reset, !vld_ff[0], req_tready, "stage 0 empty but not ready")
   `EAVR_ASSERT_NEXT(a_hold_on_stall, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "output lost on stall")
   `EAVR_ASSERT_NEXT(a_take_enters, clock, reset, req_tvalid && req_tready, vld_ff[0], "accepted item not in stage 0")
   `EAVR_ASSERT_IMPL(a_full_stall, clock, reset, (&vld_ff) && !rsp_tready, !req_tready, "full pipe took an item")

endmodule
